FILE: rtl/core/stp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the stepper ramp pulse generator
// no dependencies
package stp_pkg;

  localparam int START_SPEED    = 200;
  localparam int PULSE_PRESCALE = 8;
  localparam int RAMP_MIN_ACCEL = 1500;
  localparam int PRE_W          = (PULSE_PRESCALE > 1) ? $clog2(PULSE_PRESCALE) : 1;
  localparam int PERIOD_SHIFT   = 3;
  localparam int RELOAD_W       = 20;
  localparam int CFG_W          = 28;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_MOVE    = 3'd1,
    OP_RUN     = 3'd2,
    OP_STOP    = 3'd3,
    OP_RELEASE = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    REG_CLOCK_HZ    = 3'd0,
    REG_MAX_SPEED   = 3'd1,
    REG_ACCEL_RATE  = 3'd2,
    REG_UP_MASK     = 3'd3,
    REG_BACK_MASK   = 3'd4,
    REG_DEFAULT_DIR = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_RAMP   = 2'd0,
    DIV_AIR    = 2'd1,
    DIV_PERIOD = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_RDIV0, ST_RDIV, ST_PULSE, ST_STEP,
    ST_MUL, ST_ADIV0, ST_ADIV, ST_PDIV0, ST_PDIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     exec_cmd;
    logic     ramp_upd;
    logic     pulse_upd;
    logic     step_upd;
    logic     mul;
    logic     air_upd;
    logic     period_upd;
    logic     div_start;
    div_sel_t div_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ramp_running;
    logic       ramp_en;
    logic       blocked;
    logic       pulse_wrap;
    logic       step_load;
    logic       div_done;
  } sts_t;

endpackage

FILE: rtl/core/stp_cmd_if.sv
`timescale 1ns / 1ps
// command channel: opcode and move arguments
// no dependencies
interface stp_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] step_count;
  logic        direction;
  logic [7:0]  limit_switches;

  modport source (output valid, opcode, step_count, direction, limit_switches, input ready);
  modport sink (input valid, opcode, step_count, direction, limit_switches, output ready);
endinterface

FILE: rtl/core/stp_res_if.sv
`timescale 1ns / 1ps
// result channel: pin levels and status after each command
// no dependencies
interface stp_res_if;
  logic        valid;
  logic        ready;
  logic        pulse_out;
  logic        dir_out;
  logic        enable_n;
  logic        busy_res;
  logic [15:0] current_speed;
  logic [31:0] steps_done;

  modport source (output valid, pulse_out, dir_out, enable_n, busy_res, current_speed,
                  steps_done, input ready);
  modport sink (input valid, pulse_out, dir_out, enable_n, busy_res, current_speed,
                steps_done, output ready);
endinterface

FILE: rtl/core/stp_div.sv
`timescale 1ns / 1ps
// shared 32-bit restoring divider, one quotient bit per cycle
// no dependencies
module stp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial    = {rem, quo[31]};
  assign diff     = trial - {1'b0, dsr};
  assign quotient = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/core/stp_ctrl.sv
`timescale 1ns / 1ps
// sequencer: walks one command through ramp, pulse, step, multiply and divide phases
// depends on stp_pkg
module stp_ctrl
  import stp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_PERIOD;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.exec_cmd = 1'b1;
        if (sts.op == OP_TICK) begin
          state_next = sts.ramp_running ? ST_RDIV0 : ST_PULSE;
        end else if (sts.op == OP_MOVE || sts.op == OP_RUN) begin
          if (sts.blocked) state_next = ST_OUT;
          else if (sts.ramp_en && sts.op == OP_MOVE) state_next = ST_MUL;
          else state_next = ST_PDIV0;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_RDIV0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RAMP;
        state_next    = ST_RDIV;
      end
      ST_RDIV: begin
        if (sts.div_done) begin
          cmd.ramp_upd = 1'b1;
          state_next   = ST_PULSE;
        end
      end
      ST_PULSE: begin
        cmd.pulse_upd = 1'b1;
        state_next    = sts.pulse_wrap ? ST_STEP : ST_OUT;
      end
      ST_STEP: begin
        cmd.step_upd = 1'b1;
        state_next   = sts.step_load ? ST_PDIV0 : ST_OUT;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADIV0;
      end
      ST_ADIV0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AIR;
        state_next    = ST_ADIV;
      end
      ST_ADIV: begin
        if (sts.div_done) begin
          cmd.air_upd = 1'b1;
          state_next  = ST_PDIV0;
        end
      end
      ST_PDIV0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PERIOD;
        state_next    = ST_PDIV;
      end
      ST_PDIV: begin
        if (sts.div_done) begin
          cmd.period_upd = 1'b1;
          state_next     = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/stp_dpath.sv
`timescale 1ns / 1ps
// datapath: configuration, motion state, timers and the shared divider
// depends on stp_pkg and stp_div
module stp_dpath
  import stp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [2:0]           opcode,
  input  logic [31:0]          step_count,
  input  logic                 direction,
  input  logic [7:0]           limit_switches,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 pulse_out,
  output logic                 dir_out,
  output logic                 enable_n,
  output logic                 busy_res,
  output logic [15:0]          current_speed,
  output logic [31:0]          steps_done
);
  localparam logic [15:0]      START_V  = 16'(START_SPEED);
  localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PULSE_PRESCALE - 1);

  // configuration
  logic [27:0] clock_hz;
  logic [15:0] max_speed;
  logic [26:0] accel_rate;
  logic [7:0]  up_mask;
  logic [7:0]  back_mask;
  logic        default_dir;

  // latched command
  logic [2:0]  op;
  logic [31:0] steps;
  logic        dir;
  logic [7:0]  limits;

  // motion state
  logic [31:0]         step_counter;
  logic [31:0]         target_steps;
  logic [31:0]         decel_steps;
  logic [15:0]         ramp_speed;
  logic [31:0]         ramp_pre_cnt;
  logic                ramp_running;
  logic [RELOAD_W-1:0] pulse_count;
  logic [RELOAD_W-1:0] pulse_reload;
  logic [PRE_W-1:0]    pulse_pre;
  logic                pulse_running;
  logic                full_speed;
  logic                decelerating;
  logic                continuous;
  logic                busy_flag;
  logic                dir_pin;
  logic                enable_pin;
  logic [15:0]         loaded_speed;
  logic [15:0]         load_spd;
  logic [31:0]         product;

  // divider
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] div_a;
  logic [31:0] div_b;

  logic        ramp_en;
  logic        blocked;
  logic [31:0] rdiv;
  logic [31:0] rpc_inc;
  logic [31:0] sc1;
  logic [15:0] mirror;
  logic [15:0] mirror_cl;
  logic        step_go;
  logic        step_cruise;
  logic        step_load;
  logic [15:0] step_spd;
  logic [31:0] air;
  logic [31:0] half;

  assign ramp_en = accel_rate >= 27'(RAMP_MIN_ACCEL);
  assign blocked = (dir == 1'b0) ? ((limits & up_mask) != 8'd0)
                                 : ((limits & back_mask) != 8'd0);

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      DIV_RAMP: begin
        div_a = {4'd0, clock_hz};
        div_b = {5'd0, accel_rate};
      end
      DIV_AIR: begin
        div_a = product;
        div_b = {5'd0, accel_rate};
      end
      default: begin
        div_a = {4'd0, clock_hz};
        div_b = (load_spd == 16'd0) ? 32'd1 : {16'd0, load_spd};
      end
    endcase
  end

  stp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // ramp tick arithmetic
  assign rdiv    = (accel_rate == 27'd0 || div_q == 32'd0) ? 32'd1 : div_q;
  assign rpc_inc = ramp_pre_cnt + 32'd1;

  // step decision
  assign sc1         = step_counter + 32'd1;
  assign mirror      = max_speed - ramp_speed;
  assign mirror_cl   = (mirror < START_V) ? START_V : mirror;
  assign step_go     = (sc1 < target_steps) || continuous;
  assign step_cruise = ((target_steps - sc1) > decel_steps) || continuous;
  always_comb begin
    step_load = 1'b0;
    step_spd  = ramp_speed;
    if (step_go && ramp_en) begin
      if (step_cruise) begin
        if (!full_speed) begin
          step_load = 1'b1;
          step_spd  = (ramp_speed == max_speed) ? max_speed : ramp_speed;
        end
      end else if (decelerating) begin
        step_load = 1'b1;
        step_spd  = mirror_cl;
      end
    end
  end

  // deceleration distance
  assign air  = {1'b0, div_q[31:1]};
  assign half = {1'b0, target_steps[31:1]};

  // status back to the sequencer
  always_comb begin
    sts.op           = op;
    sts.ramp_running = ramp_running;
    sts.ramp_en      = ramp_en;
    sts.blocked      = blocked;
    sts.pulse_wrap   = pulse_running && (pulse_pre >= PRE_LAST) &&
                       (pulse_count >= pulse_reload);
    sts.step_load    = step_load;
    sts.div_done     = div_done;
  end

  // command latch and multiplier stage
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op     <= opcode;
      steps  <= step_count;
      dir    <= direction;
      limits <= limit_switches;
    end
    if (cmd.mul) begin
      product <= 32'(max_speed - START_V) * 32'(max_speed);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz    <= 28'd72000000;
      max_speed   <= 16'd20000;
      accel_rate  <= 27'd200000;
      up_mask     <= 8'd4;
      back_mask   <= 8'd8;
      default_dir <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOCK_HZ:    clock_hz    <= cfg_data;
        REG_MAX_SPEED:   max_speed   <= (cfg_data[15:0] < START_V) ? START_V : cfg_data[15:0];
        REG_ACCEL_RATE:  accel_rate  <= cfg_data[26:0];
        REG_UP_MASK:     up_mask     <= cfg_data[7:0];
        REG_BACK_MASK:   back_mask   <= cfg_data[7:0];
        REG_DEFAULT_DIR: default_dir <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter  <= '0;
      target_steps  <= 32'd10000;
      decel_steps   <= '0;
      ramp_speed    <= '0;
      ramp_pre_cnt  <= '0;
      ramp_running  <= 1'b0;
      pulse_count   <= '0;
      pulse_reload  <= RELOAD_W'(36000);
      pulse_pre     <= '0;
      pulse_running <= 1'b0;
      full_speed    <= 1'b0;
      decelerating  <= 1'b0;
      continuous    <= 1'b0;
      busy_flag     <= 1'b0;
      dir_pin       <= 1'b0;
      enable_pin    <= 1'b0;
      loaded_speed  <= '0;
      load_spd      <= '0;
    end else begin
      // non-tick commands
      if (cmd.exec_cmd) begin
        case (op)
          OP_MOVE, OP_RUN: begin
            ramp_running  <= 1'b0;
            pulse_running <= 1'b0;
            if (!blocked) begin
              enable_pin    <= 1'b0;
              dir_pin       <= (dir == default_dir);
              decelerating  <= 1'b0;
              step_counter  <= '0;
              busy_flag     <= 1'b1;
              continuous    <= (op == OP_RUN);
              if (op == OP_MOVE) target_steps <= steps;
              ramp_pre_cnt  <= '0;
              pulse_pre     <= '0;
              pulse_count   <= '0;
              pulse_running <= 1'b1;
              if (ramp_en) begin
                full_speed   <= 1'b0;
                ramp_speed   <= START_V;
                load_spd     <= START_V;
                ramp_running <= 1'b1;
              end else begin
                full_speed <= 1'b1;
                ramp_speed <= max_speed;
                load_spd   <= max_speed;
              end
            end
          end
          OP_STOP: begin
            ramp_running  <= 1'b0;
            pulse_running <= 1'b0;
            full_speed    <= 1'b0;
            decelerating  <= 1'b0;
            busy_flag     <= 1'b0;
          end
          OP_RELEASE: enable_pin <= 1'b1;
          default: ;
        endcase
      end

      // ramp timer tick
      if (cmd.ramp_upd) begin
        if (rpc_inc >= rdiv) begin
          ramp_pre_cnt <= '0;
          if (ramp_speed >= max_speed) begin
            ramp_speed   <= max_speed;
            ramp_running <= 1'b0;
          end else begin
            ramp_speed <= ramp_speed + 16'd1;
          end
        end else begin
          ramp_pre_cnt <= rpc_inc;
        end
      end

      // pulse timer tick
      if (cmd.pulse_upd && pulse_running) begin
        if (pulse_pre >= PRE_LAST) begin
          pulse_pre <= '0;
          if (pulse_count >= pulse_reload) pulse_count <= '0;
          else pulse_count <= pulse_count + RELOAD_W'(1);
        end else begin
          pulse_pre <= pulse_pre + PRE_W'(1);
        end
      end

      // one step issued
      if (cmd.step_upd) begin
        step_counter <= sc1;
        if (step_go) begin
          if (ramp_en) begin
            if (step_cruise) begin
              if (!full_speed && ramp_speed == max_speed) full_speed <= 1'b1;
            end else if (!decelerating) begin
              ramp_speed   <= mirror;
              ramp_running <= 1'b1;
              decelerating <= 1'b1;
            end
          end
        end else begin
          ramp_running  <= 1'b0;
          pulse_running <= 1'b0;
          full_speed    <= 1'b0;
          decelerating  <= 1'b0;
          busy_flag     <= 1'b0;
        end
        if (step_load) load_spd <= step_spd;
      end

      if (cmd.air_upd) begin
        decel_steps <= (half > air) ? air : half;
      end

      // period reload from the divider
      if (cmd.period_upd) begin
        pulse_reload <= div_q[RELOAD_W+PERIOD_SHIFT-1:PERIOD_SHIFT];
        loaded_speed <= load_spd;
      end
    end
  end

  // result fields
  assign pulse_out     = pulse_running && (pulse_count >= (pulse_reload >> 1));
  assign dir_out       = dir_pin;
  assign enable_n      = enable_pin;
  assign busy_res      = busy_flag;
  assign current_speed = pulse_running ? loaded_speed : 16'd0;
  assign steps_done    = step_counter;
endmodule

FILE: rtl/core/stepper_trapezoid_pulse_generator.sv
`timescale 1ns / 1ps
// top level of the stepper pulse generator with trapezoidal ramp
// depends on stp_pkg, stp_cmd_if, stp_res_if, stp_ctrl, stp_dpath
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    opcode, step_count, direction, limit_switches
//   res      out  valid/ready    pulse_out, dir_out, enable_n, busy_res, ...
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// one command at a time: stop, release or a blocked start go from decode straight
// to the result; a tick that runs the ramp and period divisions waits on the
// shared divider for each of them.
// rst is synchronous and restores the register defaults.
// res holds steady while res.ready is low; cmd.ready stays low meanwhile.
module stepper_trapezoid_pulse_generator
  import stp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  stp_cmd_if.sink              cmd,
  stp_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  cmd_t ctl_cmd;
  sts_t dp_sts;

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  stp_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (cmd.opcode),
    .step_count     (cmd.step_count),
    .direction      (cmd.direction),
    .limit_switches (cmd.limit_switches),
    .cmd            (ctl_cmd),
    .sts            (dp_sts),
    .pulse_out      (res.pulse_out),
    .dir_out        (res.dir_out),
    .enable_n       (res.enable_n),
    .busy_res       (res.busy_res),
    .current_speed  (res.current_speed),
    .steps_done     (res.steps_done)
  );
endmodule

FILE: rtl/core/stp_checker.sv
`timescale 1ns / 1ps
// port-level checks of the stepper pulse generator, bound to the top level
// depends on stepper_trapezoid_pulse_generator
module stp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        busy_res,
  input logic        pulse_out,
  input logic [15:0] current_speed,
  input logic [31:0] steps_done
);
  // never take a command while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("command taken while result pending");

  // a transfer in closes the input until its result leaves
  a_in_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after transfer");

  // a stalled result holds its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(steps_done) &&
                                   $stable(current_speed) && $stable(busy_res)))
    else $error("stalled result changed");

  // pulse pin only toggles high with the pulse timer running at some speed
  a_pulse_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pulse_out) |-> busy_res || current_speed != 16'd0)
    else $error("pulse high with timer stopped");
endmodule

bind stepper_trapezoid_pulse_generator stp_checker u_stp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (cmd.valid),
  .in_ready      (cmd.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .busy_res      (res.busy_res),
  .pulse_out     (res.pulse_out),
  .current_speed (res.current_speed),
  .steps_done    (res.steps_done)
);

FILE: dv/stepper_trapezoid_pulse_generator_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the stepper pulse generator with trapezoidal ramp
// depends on stp_pkg, stp_cmd_if, stp_res_if and the top level of the block
module stepper_trapezoid_pulse_generator_tb;
  import stp_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int TICK_CAP      = 300;

  typedef struct packed {
    logic        pulse_out;
    logic        dir_out;
    logic        enable_n;
    logic        busy_res;
    logic [15:0] current_speed;
    logic [31:0] steps_done;
  } pins_t;

  // command-level predictor of the motion controller and its result queue
  class motion_scoreboard;
    bit [31:0] clk_hz, max_spd, accel, up_mask, back_mask, def_dir;
    bit [31:0] step_cnt, target, decel_at, ramp_spd, ramp_pre, pcount, preload, ppre;
    bit [15:0] speed_loaded;
    bit ramp_on, pulse_on, at_full, in_decel, cont, busy, dir_pin, en_pin;
    pins_t pins_q[$];
    int errors;

    function new();
      clk_hz = 72000000; max_spd = 20000; accel = 200000;
      up_mask = 4; back_mask = 8; def_dir = 0;
      step_cnt = 0; target = 10000; decel_at = 0; ramp_spd = 0; ramp_pre = 0;
      pcount = 0; preload = 36000; ppre = 0; speed_loaded = 0;
      ramp_on = 0; pulse_on = 0; at_full = 0; in_decel = 0; cont = 0;
      busy = 0; dir_pin = 0; en_pin = 0; errors = 0;
    endfunction

    function bit [31:0] floor_speed(bit [31:0] v);
      return (v < START_SPEED) ? START_SPEED : v;
    endfunction

    function void write_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_CLOCK_HZ:    clk_hz = v & 32'hFFFFFFF;
        REG_MAX_SPEED:   max_spd = floor_speed(v & 32'hFFFF);
        REG_ACCEL_RATE:  accel = v & 32'h7FFFFFF;
        REG_UP_MASK:     up_mask = v & 32'hFF;
        REG_BACK_MASK:   back_mask = v & 32'hFF;
        REG_DEFAULT_DIR: def_dir = v & 32'h1;
        default: ;
      endcase
    endfunction

    function void set_period(bit [31:0] spd);
      bit [31:0] s;
      s = (spd == 0) ? 1 : spd;
      preload = ((clk_hz / s) >> PERIOD_SHIFT) & 32'hFFFFF;
      speed_loaded = spd[15:0];
    endfunction

    function bit ramp_ok();
      return accel >= RAMP_MIN_ACCEL;
    endfunction

    function void halt_all();
      ramp_on = 0; pulse_on = 0; at_full = 0; in_decel = 0; busy = 0;
    endfunction

    function void begin_motion(logic [2:0] op, bit [31:0] steps, bit d, bit [7:0] lim);
      longint unsigned span;
      bit [31:0] air, half;
      ramp_on = 0; pulse_on = 0;
      if (d == 0 ? ((lim & up_mask) != 0) : ((lim & back_mask) != 0)) return;
      en_pin = 0; dir_pin = (d == def_dir); in_decel = 0; step_cnt = 0; busy = 1;
      cont = (op == OP_RUN);
      if (op == OP_MOVE) target = steps;
      ramp_pre = 0; ppre = 0; pcount = 0;
      if (ramp_ok()) begin
        at_full = 0;
        if (op == OP_MOVE) begin
          span = longint'(max_spd - START_SPEED) * longint'(max_spd);
          air = 32'((span / accel) >> 1);
          half = target >> 1;
          decel_at = (half > air) ? air : half;
        end
        ramp_spd = START_SPEED;
        set_period(ramp_spd);
        ramp_on = 1;
      end else begin
        at_full = 1;
        ramp_spd = max_spd;
        set_period(max_spd);
      end
      pulse_on = 1;
    endfunction

    function void take_step();
      step_cnt++;
      if (step_cnt < target || cont) begin
        if (!ramp_ok()) return;
        if ((target - step_cnt) > decel_at || cont) begin
          if (!at_full) begin
            if (ramp_spd == max_spd) begin
              at_full = 1;
              set_period(max_spd);
            end else begin
              set_period(ramp_spd);
            end
          end
        end else if (!in_decel) begin
          ramp_spd = (max_spd - ramp_spd) & 32'hFFFF;
          ramp_on = 1;
          in_decel = 1;
        end else begin
          set_period(floor_speed((max_spd - ramp_spd) & 32'hFFFF));
        end
      end else begin
        halt_all();
      end
    endfunction

    function void core_tick();
      bit [31:0] div;
      if (ramp_on) begin
        div = (accel == 0) ? 1 : clk_hz / accel;
        if (div == 0) div = 1;
        ramp_pre++;
        if (ramp_pre >= div) begin
          ramp_pre = 0;
          if (ramp_spd >= max_spd) begin
            ramp_spd = max_spd;
            ramp_on = 0;
          end else begin
            ramp_spd++;
          end
        end
      end
      if (pulse_on) begin
        ppre++;
        if (ppre >= PULSE_PRESCALE) begin
          ppre = 0;
          if (pcount >= preload) begin
            pcount = 0;
            take_step();
          end else begin
            pcount++;
          end
        end
      end
    endfunction

    // accepted command: advance the model and queue the pin levels it leads to
    function void note_command(logic [2:0] op, bit [31:0] steps, bit d, bit [7:0] lim);
      pins_t p;
      case (op)
        OP_TICK: core_tick();
        OP_MOVE, OP_RUN: begin_motion(op, steps, d, lim);
        OP_STOP: halt_all();
        OP_RELEASE: en_pin = 1;
        default: ;
      endcase
      p.pulse_out = pulse_on && (pcount >= (preload >> 1));
      p.dir_out = dir_pin;
      p.enable_n = en_pin;
      p.busy_res = busy;
      p.current_speed = pulse_on ? speed_loaded : 16'd0;
      p.steps_done = step_cnt;
      pins_q.push_back(p);
    endfunction

    function void check_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(pins_t got);
      pins_t e;
      if (pins_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = pins_q.pop_front();
      check_field("pulse_out", e.pulse_out, got.pulse_out);
      check_field("dir_out", e.dir_out, got.dir_out);
      check_field("enable_n", e.enable_n, got.enable_n);
      check_field("busy_res", e.busy_res, got.busy_res);
      check_field("current_speed", e.current_speed, got.current_speed);
      check_field("steps_done", e.steps_done, got.steps_done);
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  bit tx_gaps, rx_steady, hold_req;
  motion_scoreboard sb;

  stp_cmd_if cmd_ch();
  stp_res_if res_ch();

  stepper_trapezoid_pulse_generator i_dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  // result receiver with random stalls and a long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        res_ch.ready = rx_steady ? 1'b1 : ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result({res_ch.pulse_out, res_ch.dir_out, res_ch.enable_n, res_ch.busy_res,
                       res_ch.current_speed, res_ch.steps_done});
  end

  // one command transfer, with an occasional gap before it
  task automatic send_cmd(logic [2:0] op, bit [31:0] steps, bit d, bit [7:0] lim);
    if (tx_gaps && $urandom_range(0, 99) < 12) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.opcode = op;
    cmd_ch.step_count = steps;
    cmd_ch.direction = d;
    cmd_ch.limit_switches = lim;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_command(op, steps, d, lim);
    @(negedge clk);
    cmd_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pins_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, bit [31:0] v);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v[CFG_W-1:0];
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(bit [31:0] hz, bit [31:0] spd, bit [31:0] acc,
                         bit [31:0] um, bit [31:0] bm, bit [31:0] dd);
    set_reg(REG_CLOCK_HZ, hz);
    set_reg(REG_MAX_SPEED, spd);
    set_reg(REG_ACCEL_RATE, acc);
    set_reg(REG_UP_MASK, um);
    set_reg(REG_BACK_MASK, bm);
    set_reg(REG_DEFAULT_DIR, dd);
  endtask

  // ticks until the predicted motion ends, bounded
  task automatic tick_until_idle();
    int n;
    n = 0;
    while (sb.busy && n < TICK_CAP) begin
      send_cmd(OP_TICK, $urandom, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      n++;
    end
  endtask

  // one random command, ticks taking tick_pct percent of them
  task automatic random_item(int tick_pct);
    int r;
    int k;
    logic [2:0] op;
    bit [31:0] steps;
    bit [7:0] lim;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (r < tick_pct) op = OP_TICK;
    else if (k < 40) op = OP_MOVE;
    else if (k < 55) op = OP_RUN;
    else if (k < 75) op = OP_STOP;
    else if (k < 90) op = OP_RELEASE;
    else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    steps = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40) : $urandom;
    lim = ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom_range(0, 255));
    send_cmd(op, steps, 1'($urandom_range(0, 1)), lim);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    cmd_ch.valid = 1'b0; cmd_ch.opcode = OP_TICK; cmd_ch.step_count = '0;
    cmd_ch.direction = 1'b0; cmd_ch.limit_switches = '0;
    tx_gaps = 1'b1; rx_steady = 1'b0; hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every opcode, limit blocking, extreme fields, under reset settings
    send_cmd(OP_TICK, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_MOVE, 32'hFFFFFFFF, 1'b0, 8'd0);
    repeat (4) send_cmd(OP_TICK, 32'hFFFFFFFF, 1'b1, 8'hFF);
    send_cmd(OP_RELEASE, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_TICK, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_MOVE, 32'd5, 1'b0, 8'h04);
    send_cmd(OP_RUN, 32'd0, 1'b1, 8'h08);
    send_cmd(OP_RUN, 32'd0, 1'b1, 8'h04);
    send_cmd(OP_TICK, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_STOP, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_SPARE_LO, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_SPARE_HI, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_MOVE, 32'd0, 1'b1, 8'd0);

    // random traffic under reset settings
    repeat (150) random_item(80);

    // no ramp, fast steps, a long stretch without idling on either side
    set_all(32'd1000000, 32'd65535, 32'd0, 32'd4, 32'd8, 32'd0);
    tx_gaps = 1'b0;
    rx_steady = 1'b1;
    repeat (250) random_item(80);
    tx_gaps = 1'b1;
    rx_steady = 1'b0;

    // ramp with deceleration at a slow clock
    set_all(32'd4000, 32'd300, 32'd5000, 32'hF0, 32'h0F, 32'd1);
    send_cmd(OP_MOVE, 32'd6, 1'b0, 8'd0);
    tick_until_idle();
    send_cmd(OP_RUN, 32'd0, 1'b1, 8'hF0);
    repeat (100) send_cmd(OP_TICK, 32'd0, 1'b0, 8'd0);
    send_cmd(OP_STOP, 32'd0, 1'b0, 8'd0);

    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    repeat (20) random_item(90);
    wait_idle();
    repeat (300) random_item(95);

    // speed clamped to the start speed, fastest ramp
    set_all(32'd4000, 32'd50, 32'd100000000, 32'd1, 32'd2, 32'd0);
    repeat (150) random_item(90);

    wait_idle();
    if (sb.errors == 0 && sb.pins_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/stp_pkg.sv
rtl/core/stp_cmd_if.sv
rtl/core/stp_res_if.sv
rtl/core/stp_div.sv
rtl/core/stp_ctrl.sv
rtl/core/stp_dpath.sv
rtl/core/stepper_trapezoid_pulse_generator.sv
rtl/core/stp_checker.sv
dv/stepper_trapezoid_pulse_generator_tb.sv
